@@ rtl/lud_pkg.sv @@
`timescale 1ns / 1ps

package lud_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int NEL       = DIM * DIM;
  localparam int IDX_W     = $clog2(DIM);
  localparam int ADDR_W    = $clog2(NEL);
  localparam int CNT_W     = $clog2(DIM + 1);
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 64;
  localparam int MEM_W     = DATA_W + 1;

  localparam logic signed [DATA_W-1:0] Q_ONE =
    {{(DATA_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] Q_MAX_W =
    {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Q_MIN_W =
    {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  // output_select codes, anything else means inverse of A
  localparam logic [2:0] SEL_INV_A = 3'd0;
  localparam logic [2:0] SEL_L     = 3'd1;
  localparam logic [2:0] SEL_U     = 3'd2;
  localparam logic [2:0] SEL_INV_L = 3'd3;
  localparam logic [2:0] SEL_INV_U = 3'd4;

  typedef enum logic [1:0] {
    INIT_ZERO = 2'd0,
    INIT_MEM  = 2'd1,
    INIT_ONE  = 2'd2
  } init_t;

  typedef enum logic [1:0] {
    SRC_WM = 2'd0,
    SRC_UI = 2'd1,
    SRC_LI = 2'd2
  } src_t;

  typedef struct packed {
    logic  valid;
    logic  first;
    logic  sub;
    init_t init;
  } mac_ctl_t;

  typedef struct packed {
    logic                     clip;
    logic signed [DATA_W-1:0] val;
  } satv_t;

  function automatic satv_t sat_q(input logic signed [ACC_W-1:0] v);
    satv_t r;
    if (v > Q_MAX_W) begin
      r.clip = 1'b1;
      r.val  = Q_MAX;
    end else if (v < Q_MIN_W) begin
      r.clip = 1'b1;
      r.val  = Q_MIN;
    end else begin
      r.clip = 1'b0;
      r.val  = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] row,
                                                input logic [IDX_W-1:0] col);
    return ADDR_W'(int'(row) * DIM + int'(col));
  endfunction

endpackage

@@ rtl/lud_ifs.sv @@
`timescale 1ns / 1ps

interface lud_elem_if;
  logic                             valid;
  logic                             ready;
  logic signed [lud_pkg::DATA_W-1:0] matrix_element;
  modport source (output valid, output matrix_element, input ready);
  modport sink   (input valid, input matrix_element, output ready);
endinterface

interface lud_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [lud_pkg::DATA_W-1:0] result_value;
  logic [1:0]                       row_index;
  logic [1:0]                       col_index;
  logic                             is_singular;
  logic                             saturated;
  logic                             last_of_run;
  modport source (output valid, output result_value, output row_index, output col_index,
                  output is_singular, output saturated, output last_of_run, input ready);
  modport sink   (input valid, input result_value, input row_index, input col_index,
                  input is_singular, input saturated, input last_of_run, output ready);
endinterface

interface lud_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] output_select;
  modport source (output valid, output output_select, input ready);
  modport sink   (input valid, input output_select, output ready);
endinterface

@@ rtl/lud_ram.sv @@
`timescale 1ns / 1ps

module lud_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ rtl/lud_mac.sv @@
`timescale 1ns / 1ps

module lud_mac (
  input  logic                             clk,
  input  logic                             rst,
  input  lud_pkg::mac_ctl_t                ctl,
  input  logic signed [lud_pkg::DATA_W-1:0] a_val,
  input  logic                             a_clip,
  input  logic signed [lud_pkg::DATA_W-1:0] b_val,
  output logic signed [lud_pkg::ACC_W-1:0]  acc,
  output logic                             acc_clip,
  output logic                             busy
);
  import lud_pkg::*;

  mac_ctl_t                 p_ctl;
  logic signed [ACC_W-1:0]  prod;
  logic signed [ACC_W-1:0]  init_val;
  logic                     init_clip;
  logic signed [ACC_W-1:0]  term;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctl <= '0;
    end else begin
      p_ctl <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod <= ACC_W'(a_val) * ACC_W'(b_val);
    case (ctl.init)
      INIT_MEM: init_val <= ACC_W'(a_val);
      INIT_ONE: init_val <= ACC_W'(Q_ONE);
      default:  init_val <= '0;
    endcase
    init_clip <= (ctl.init == INIT_MEM) && a_clip;
  end

  // floor shift, exact for both signs
  assign term = prod >>> FRAC_BITS;

  // accumulate stage
  always_ff @(posedge clk) begin
    if (p_ctl.valid) begin
      if (p_ctl.first) begin
        acc      <= init_val;
        acc_clip <= init_clip;
      end else if (p_ctl.sub) begin
        acc <= acc - term;
      end else begin
        acc <= acc + term;
      end
    end
  end

  assign busy = ctl.valid | p_ctl.valid;

endmodule

@@ rtl/lud_div.sv @@
`timescale 1ns / 1ps

module lud_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [lud_pkg::ACC_W-1:0]  num,
  input  logic signed [lud_pkg::DATA_W-1:0] den,
  output logic                             busy,
  output lud_pkg::satv_t                   quot
);
  import lud_pkg::*;

  localparam int QW     = DATA_W + FRAC_BITS;
  localparam int STEP_W = $clog2(QW + 1);
  localparam logic [QW-1:0] MAG_POS = {{(QW-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic [QW-1:0] MAG_NEG = {{(QW-DATA_W){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}};

  logic [QW-1:0]     dvd;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dmag;
  logic              neg;
  logic              clip_in;
  logic [STEP_W-1:0] steps;
  satv_t             ns;
  logic [DATA_W-1:0] nmag;
  logic [DATA_W:0]   rem_sh;
  logic              ge;

  assign ns     = sat_q(num);
  assign nmag   = ns.val[DATA_W-1] ? DATA_W'(-ns.val) : DATA_W'(ns.val);
  assign rem_sh = {rem, dvd[QW-1]};
  assign ge     = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(QW);
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // restoring division on magnitudes, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      dvd     <= {nmag, {FRAC_BITS{1'b0}}};
      rem     <= '0;
      dmag    <= den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
      neg     <= ns.val[DATA_W-1] ^ den[DATA_W-1];
      clip_in <= ns.clip;
    end else if (busy) begin
      rem <= DATA_W'(ge ? (rem_sh - {1'b0, dmag}) : rem_sh);
      dvd <= {dvd[QW-2:0], ge};
    end
  end

  always_comb begin
    quot.clip = clip_in;
    if (neg) begin
      if (dvd > MAG_NEG) begin
        quot.clip = 1'b1;
        quot.val  = Q_MIN;
      end else begin
        quot.val = -$signed(dvd[DATA_W-1:0]);
      end
    end else begin
      if (dvd > MAG_POS) begin
        quot.clip = 1'b1;
        quot.val  = Q_MAX;
      end else begin
        quot.val = $signed(dvd[DATA_W-1:0]);
      end
    end
  end

endmodule

@@ rtl/lu_decompose_and_invert.sv @@
`timescale 1ns / 1ps

// channel     modport  beat payload
// matrix_in   sink     matrix_element, one element per beat, row-major
// result_out  source   result_value, row_index, col_index, is_singular, saturated,
//                      last_of_run
// cfg         sink     output_select, always ready
//
// sixteen load beats, one per cycle while matrix_in is valid, then the run, which is
// set by the shared divider, sixteen quotients (six for L, ten for inv(U)), plus the
// issue, drain and store states of each element and one issue slot per
// multiply-accumulate term. the run halts while result_out stalls, and matrix_in
// takes nothing until the last result beat is taken. reset clears control only,
// the three memories are written before they are read.

module lu_decompose_and_invert (
  input  logic                clk,
  input  logic                rst,
  lud_elem_if.sink            matrix_in,
  lud_result_if.source        result_out,
  lud_cfg_if.sink             cfg
);
  import lud_pkg::*;

  typedef enum logic [5:0] {
    ST_LOAD   = 6'b000001,
    ST_ISSUE  = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_DIVIDE = 6'b001000,
    ST_STORE  = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    PH_FU  = 3'd0,
    PH_FL  = 3'd1,
    PH_UI  = 3'd2,
    PH_LI  = 3'd3,
    PH_OUT = 3'd4
  } phase_t;

  state_t                   state;
  phase_t                   phase;
  logic [IDX_W-1:0]         r;
  logic [IDX_W-1:0]         c;
  logic [CNT_W-1:0]         t;
  logic [ADDR_W-1:0]        load_count;
  logic [2:0]               out_select;
  logic signed [DATA_W-1:0] piv [DIM];

  // output register
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_value;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic                     out_sing;
  logic                     out_sat;
  logic                     out_last;

  // job decode
  logic [CNT_W-1:0] n_terms;
  logic [IDX_W-1:0] a_row, a_col, b_row, b_col, div_idx;
  init_t            init_kind;
  logic             sub_terms, fin_div, fin_pass;
  src_t             init_src, term_src_a, term_src_b, dest_src;

  // next job
  phase_t           phase_next;
  logic [IDX_W-1:0] r_next, c_next;
  logic             last_r, last_c;

  // memories and datapath
  logic [ADDR_W-1:0] addr_a, addr_b, wm_waddr;
  logic [MEM_W-1:0]  wm_wdata, wm_ra, wm_rb, ui_ra, ui_rb, li_ra, li_rb;
  logic              wm_we, ui_we, li_we;
  src_t              src_a_q, src_b_q;
  mac_ctl_t          ctl_issue, ctl_q;
  satv_t             a_word, b_word;
  logic signed [ACC_W-1:0] acc;
  logic              acc_clip, mac_busy;
  logic              div_start, div_busy;
  satv_t             div_quot;
  satv_t             fin, shown;

  function automatic logic [IDX_W-1:0] ix(input int v);
    return IDX_W'(v);
  endfunction

  assign last_r = (r == IDX_W'(DIM - 1));
  assign last_c = (c == IDX_W'(DIM - 1));

  // operands and bounds of the element being worked on
  always_comb begin
    int u;
    int jj;
    int mm;
    u          = int'(t) - 1;
    jj         = 0;
    mm         = (r > c) ? int'(r) : int'(c);
    n_terms    = '0;
    a_row      = r;
    a_col      = c;
    b_row      = r;
    b_col      = c;
    init_kind  = INIT_ZERO;
    sub_terms  = 1'b1;
    fin_div    = 1'b0;
    fin_pass   = 1'b0;
    init_src   = SRC_WM;
    term_src_a = SRC_WM;
    term_src_b = SRC_WM;
    dest_src   = SRC_WM;
    div_idx    = c;
    case (phase)
      PH_FU: begin
        n_terms   = CNT_W'(r);
        a_col     = ix(u);
        b_row     = ix(u);
        init_kind = INIT_MEM;
      end
      PH_FL: begin
        n_terms   = CNT_W'(c);
        a_col     = ix(u);
        b_row     = ix(u);
        init_kind = INIT_MEM;
        fin_div   = 1'b1;
        div_idx   = c;
      end
      PH_UI: begin
        jj         = int'(r) + int'(t);
        n_terms    = CNT_W'(int'(c) - int'(r));
        a_col      = ix(jj);
        b_row      = ix(jj);
        term_src_b = SRC_UI;
        init_kind  = (r == c) ? INIT_ONE : INIT_ZERO;
        fin_div    = 1'b1;
        div_idx    = r;
        dest_src   = SRC_UI;
      end
      PH_LI: begin
        jj         = int'(c) + u;
        n_terms    = CNT_W'(int'(r) - int'(c));
        a_col      = ix(jj);
        b_row      = ix(jj);
        term_src_b = SRC_LI;
        init_kind  = (r == c) ? INIT_ONE : INIT_ZERO;
        dest_src   = SRC_LI;
      end
      PH_OUT: begin
        if (out_select inside {SEL_L, SEL_U, SEL_INV_L, SEL_INV_U}) begin
          // stored matrix read straight through
          init_kind = INIT_MEM;
          fin_pass  = 1'b1;
          if (out_select == SEL_INV_L) begin
            init_src = SRC_LI;
          end else if (out_select == SEL_INV_U) begin
            init_src = SRC_UI;
          end
        end else begin
          // inv(U) * inv(L), only the triangles overlap
          jj         = mm + u;
          n_terms    = CNT_W'(DIM - mm);
          a_col      = ix(jj);
          b_row      = ix(jj);
          term_src_a = SRC_UI;
          term_src_b = SRC_LI;
          sub_terms  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // walk order: U row k, L column k, inv(U) columns bottom-up, inv(L) columns, then results row by row
  always_comb begin
    phase_next = phase;
    r_next     = r;
    c_next     = c;
    case (phase)
      PH_FU: begin
        if (!last_c) begin
          c_next = c + IDX_W'(1);
        end else if (!last_r) begin
          phase_next = PH_FL;
          r_next     = r + IDX_W'(1);
          c_next     = r;
        end else begin
          phase_next = PH_UI;
          r_next     = '0;
          c_next     = '0;
        end
      end
      PH_FL: begin
        if (!last_r) begin
          r_next = r + IDX_W'(1);
        end else begin
          phase_next = PH_FU;
          r_next     = c + IDX_W'(1);
          c_next     = c + IDX_W'(1);
        end
      end
      PH_UI: begin
        if (r != '0) begin
          r_next = r - IDX_W'(1);
        end else if (!last_c) begin
          c_next = c + IDX_W'(1);
          r_next = c + IDX_W'(1);
        end else begin
          phase_next = PH_LI;
          r_next     = '0;
          c_next     = '0;
        end
      end
      PH_LI: begin
        if (!last_r) begin
          r_next = r + IDX_W'(1);
        end else if (!last_c) begin
          c_next = c + IDX_W'(1);
          r_next = c + IDX_W'(1);
        end else begin
          phase_next = PH_OUT;
          r_next     = '0;
          c_next     = '0;
        end
      end
      PH_OUT: begin
        if (!last_c) begin
          c_next = c + IDX_W'(1);
        end else begin
          c_next = '0;
          r_next = r + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // first issue slot reads the element itself, the rest read term operands
  assign addr_a = (t == '0) ? addr_of(r, c) : addr_of(a_row, a_col);
  assign addr_b = addr_of(b_row, b_col);

  assign ctl_issue.valid = (state == ST_ISSUE);
  assign ctl_issue.first = (t == '0);
  assign ctl_issue.sub   = sub_terms;
  assign ctl_issue.init  = init_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_issue;
    end
  end

  always_ff @(posedge clk) begin
    src_a_q <= (t == '0) ? init_src : term_src_a;
    src_b_q <= term_src_b;
  end

  always_comb begin
    case (src_a_q)
      SRC_UI:  a_word = satv_t'(ui_ra);
      SRC_LI:  a_word = satv_t'(li_ra);
      default: a_word = satv_t'(wm_ra);
    endcase
    case (src_b_q)
      SRC_UI:  b_word = satv_t'(ui_rb);
      SRC_LI:  b_word = satv_t'(li_rb);
      default: b_word = satv_t'(wm_rb);
    endcase
  end

  // work memory: loaded elements, then L below the diagonal and U on and above it
  assign wm_we    = (state == ST_LOAD && matrix_in.valid) ||
                    (state == ST_STORE && dest_src == SRC_WM && phase != PH_OUT);
  assign wm_waddr = (state == ST_LOAD) ? load_count : addr_of(r, c);
  assign wm_wdata = (state == ST_LOAD) ? MEM_W'({1'b0, matrix_in.matrix_element}) :
                                         MEM_W'(fin);
  assign ui_we    = (state == ST_STORE) && (phase == PH_UI);
  assign li_we    = (state == ST_STORE) && (phase == PH_LI);

  lud_ram #(.WIDTH(MEM_W), .DEPTH(NEL)) u_wm (
    .clk, .we(wm_we), .waddr(wm_waddr), .wdata(wm_wdata),
    .raddr_a(addr_a), .raddr_b(addr_b), .rdata_a(wm_ra), .rdata_b(wm_rb)
  );

  lud_ram #(.WIDTH(MEM_W), .DEPTH(NEL)) u_ui (
    .clk, .we(ui_we), .waddr(addr_of(r, c)), .wdata(MEM_W'(fin)),
    .raddr_a(addr_a), .raddr_b(addr_b), .rdata_a(ui_ra), .rdata_b(ui_rb)
  );

  lud_ram #(.WIDTH(MEM_W), .DEPTH(NEL)) u_li (
    .clk, .we(li_we), .waddr(addr_of(r, c)), .wdata(MEM_W'(fin)),
    .raddr_a(addr_a), .raddr_b(addr_b), .rdata_a(li_ra), .rdata_b(li_rb)
  );

  lud_mac u_mac (
    .clk, .rst, .ctl(ctl_q),
    .a_val(a_word.val), .a_clip(a_word.clip), .b_val(b_word.val),
    .acc, .acc_clip, .busy(mac_busy)
  );

  assign div_start = (state == ST_DRAIN) && !mac_busy && fin_div;

  lud_div u_div (
    .clk, .rst, .start(div_start), .num(acc), .den(piv[div_idx]),
    .busy(div_busy), .quot(div_quot)
  );

  // final value of the element
  always_comb begin
    if (fin_div) begin
      fin = div_quot;
    end else if (fin_pass) begin
      fin.clip = acc_clip;
      fin.val  = acc[DATA_W-1:0];
    end else begin
      fin = sat_q(acc);
    end
  end

  // triangle masks of the stored matrices
  always_comb begin
    shown = fin;
    case (out_select)
      SEL_L: begin
        if (r == c) begin
          shown.val  = Q_ONE;
          shown.clip = 1'b0;
        end else if (r < c) begin
          shown = '0;
        end
      end
      SEL_U, SEL_INV_U: begin
        if (r > c) begin
          shown = '0;
        end
      end
      SEL_INV_L: begin
        if (r < c) begin
          shown = '0;
        end
      end
      default: ;
    endcase
  end

  assign matrix_in.ready = (state == ST_LOAD);
  assign cfg.ready       = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_select <= SEL_INV_A;
    end else if (cfg.valid) begin
      out_select <= cfg.output_select;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_STORE && phase == PH_FU && r == c) begin
      piv[r] <= fin.val;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      phase      <= PH_FU;
      r          <= '0;
      c          <= '0;
      t          <= '0;
      load_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (matrix_in.valid) begin
            if (load_count == ADDR_W'(NEL - 1)) begin
              load_count <= '0;
              phase      <= PH_FU;
              r          <= '0;
              c          <= '0;
              t          <= '0;
              state      <= ST_ISSUE;
            end else begin
              load_count <= load_count + ADDR_W'(1);
            end
          end
        end
        ST_ISSUE: begin
          if (t == n_terms) begin
            state <= ST_DRAIN;
          end else begin
            t <= t + CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!mac_busy) begin
            state <= fin_div ? ST_DIVIDE : ST_STORE;
          end
        end
        ST_DIVIDE: begin
          if (!div_busy) begin
            state <= ST_STORE;
          end
        end
        ST_STORE: begin
          t <= '0;
          if (phase == PH_OUT) begin
            out_valid <= 1'b1;
            out_value <= shown.val;
            out_sat   <= shown.clip;
            out_row   <= r;
            out_col   <= c;
            out_sing  <= 1'b0;
            out_last  <= last_r && last_c;
            state     <= ST_EMIT;
          end else if (phase == PH_FU && r == c && fin.val == '0) begin
            // zero pivot, one singular beat ends the run
            out_valid <= 1'b1;
            out_value <= '0;
            out_sat   <= 1'b0;
            out_row   <= '0;
            out_col   <= '0;
            out_sing  <= 1'b1;
            out_last  <= 1'b1;
            state     <= ST_EMIT;
          end else begin
            phase <= phase_next;
            r     <= r_next;
            c     <= c_next;
            state <= ST_ISSUE;
          end
        end
        ST_EMIT: begin
          if (result_out.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              state <= ST_LOAD;
            end else begin
              phase <= phase_next;
              r     <= r_next;
              c     <= c_next;
              state <= ST_ISSUE;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.result_value = out_value;
  assign result_out.row_index    = 2'(out_row);
  assign result_out.col_index    = 2'(out_col);
  assign result_out.is_singular  = out_sing;
  assign result_out.saturated    = out_sat;
  assign result_out.last_of_run  = out_last;

  // no load beat while a result is pending
  a_load_vs_emit: assert property (@(posedge clk) disable iff (rst)
    matrix_in.valid && matrix_in.ready |-> !out_valid)
    else $error("load beat taken while a result is pending");

  // a singular beat is a lone zero beat closing the run
  a_singular_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_sing |-> out_last && out_value == '0 && !out_sat)
    else $error("malformed singular beat");

  // the divider is never restarted mid-quotient
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // an element is stored only once the accumulator and divider have settled
  a_store_settled: assert property (@(posedge clk) disable iff (rst)
    state == ST_STORE |-> !mac_busy && !div_busy)
    else $error("store before datapath settled");

endmodule
